>>> sv/dsmsr_pkg.sv
// Shared constants, codes and types of the serial receiver frame decoder.
package dsmsr_pkg;

  // Frame geometry and channel store size.
  localparam int FRAME_BYTES     = 16;
  localparam int WORDS_PER_FRAME = 7;
  localparam int NUM_CHANNELS    = 12;

  // The frame buffer keeps bytes in pairs, one 16-bit entry per pair.
  localparam int FRAME_PAIRS = (FRAME_BYTES + 1) / 2;
  localparam int PAIR_W      = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;
  localparam int BIDX_W      = $clog2(FRAME_BYTES + 1);
  localparam int SEQ_W       = $clog2(WORDS_PER_FRAME + FRAME_PAIRS + 2);
  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Byte positions that feed resolution detection.
  localparam logic [BIDX_W-1:0] POS_INFO    = BIDX_W'(1);
  localparam logic [BIDX_W-1:0] POS_WORD0_H = BIDX_W'(2);
  localparam logic [BIDX_W-1:0] POS_WORD0_L = BIDX_W'(3);
  localparam logic [BIDX_W-1:0] POS_WORD1_H = BIDX_W'(4);
  localparam logic [BIDX_W-1:0] POS_WORD1_L = BIDX_W'(5);

  // Input command codes.
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Channel read status codes.
  localparam logic [1:0] ST_VALID      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT    = 2'd1;
  localparam logic [1:0] ST_NO_CHANNEL = 2'd2;

  // Frame event codes.
  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_DECODED     = 2'd1;
  localparam logic [1:0] EV_RES_UNKNOWN = 2'd2;
  localparam logic [1:0] EV_FRAME_ERROR = 2'd3;

  // Resolution codes.
  localparam logic [1:0] RES_UNKNOWN = 2'd0;
  localparam logic [1:0] RES_TEN     = 2'd1;
  localparam logic [1:0] RES_ELEVEN  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SECOND_FRAME_MASK    = 2'd0;
  localparam logic [1:0] REG_INFO_RESOLUTION_MASK = 2'd1;
  localparam logic [1:0] REG_SYNC_IDLE_TICKS      = 2'd2;
  localparam logic [1:0] REG_FAILSAFE_TICKS       = 2'd3;

  // A channel word with every bit set carries no channel.
  localparam logic [15:0] WORD_EMPTY = 16'hffff;

  // Classified operation of one input word.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [3:0] channel_index;
  } item_t;

  typedef struct packed {
    logic [10:0] channel_value;
    logic [1:0]  channel_status;
    logic [1:0]  frame_event;
    logic        failsafe_fired;
    logic [1:0]  resolution_state;
  } result_t;

  typedef struct packed {
    logic [15:0] second_frame_mask;
    logic [7:0]  info_resolution_mask;
    logic [7:0]  sync_idle_ticks;
    logic [7:0]  failsafe_ticks;
  } cfg_t;

endpackage

>>> sv/dsmsr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dsmsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/dsmsr_front.sv
// Front end: accepts input words, classifies the command and queues them.
module dsmsr_front import dsmsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [3:0] channel_index,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t      slots [2];
  item_t      incoming;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;

  // Classify the command of the incoming word.
  always_comb begin
    incoming.data_byte     = data_byte;
    incoming.channel_index = channel_index;
    unique case (cmd)
      CMD_BYTE: incoming.op = OP_BYTE;
      CMD_TICK: incoming.op = OP_TICK;
      CMD_READ: incoming.op = OP_READ;
      default:  incoming.op = OP_NONE;
    endcase
  end

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, item_take};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

>>> sv/dsmsr_back.sv
// Back end: frame capture, resolution detection, word unpacking and channel store.
module dsmsr_back import dsmsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_take,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res,
  output logic [1:0] resolution
);

  typedef enum logic [1:0] {
    S_RUN,
    S_DETECT,
    S_READ,
    S_WORD
  } state_t;

  localparam logic [3:0] PAT_FIRST_CH  = 4'd1;
  localparam logic [3:0] PAT_SECOND_CH = 4'd5;

  state_t              state;
  logic [7:0]          idle_count;
  logic [7:0]          failsafe_count;
  logic                capturing;
  logic [BIDX_W-1:0]   byte_index;
  logic [1:0]          detected_res;
  logic [NUM_CHANNELS-1:0] fresh;
  logic [10:0]         store [NUM_CHANNELS];
  logic [7:0]          info_byte;
  logic [15:0]         word0;
  logic [15:0]         word1;
  logic [7:0]          hi_byte;
  logic [SEQ_W-1:0]    word_num;
  logic                pair_ok;

  logic                start;
  logic                byte_store;
  logic                last_byte;
  logic                arm;
  logic                fire;
  logic [7:0]          idle_inc;
  logic [7:0]          fs_inc;
  logic                read_ok;
  logic [CH_W-1:0]     read_sel;
  logic [1:0]          detect_res;
  logic [1:0]          res_sel;
  logic [SEQ_W-1:0]    pair_num;
  logic                pair_in;
  logic                ram_we;
  logic [PAIR_W-1:0]   ram_waddr;
  logic [15:0]         ram_wdata;
  logic [15:0]         ram_rdata;
  logic [15:0]         word_cur;
  logic [3:0]          word_ch;
  logic [10:0]         word_val;
  logic                word_skip;
  logic                word_abort;
  logic                word_last;
  logic                word_write;

  // Resolution from the information byte, or from the channel order of words 0 and 1.
  function automatic logic [1:0] detect_resolution(input logic [7:0] info,
                                                   input logic [15:0] w0,
                                                   input logic [15:0] w1,
                                                   input cfg_t c);
    logic       ten;
    logic       eleven;
    logic [1:0] r;
    ten    = (w0[13:10] == PAT_FIRST_CH) && (w1[13:10] == PAT_SECOND_CH);
    eleven = (w0[14:11] == PAT_FIRST_CH) && (w1[14:11] == PAT_SECOND_CH);
    if ((w0 & c.second_frame_mask) != 16'h0000) begin
      r = RES_UNKNOWN;
    end else if (info != 8'h00) begin
      r = ((info & c.info_resolution_mask) != 8'h00) ? RES_ELEVEN : RES_TEN;
    end else if (ten && !eleven) begin
      r = RES_TEN;
    end else if (eleven && !ten) begin
      r = RES_ELEVEN;
    end else begin
      r = RES_UNKNOWN;
    end
    return r;
  endfunction

  // Item start and per-command conditions.
  assign start      = (state == S_RUN) && item_valid && !res_full;
  assign item_take  = start;
  assign byte_store = start && (item.op == OP_BYTE) && capturing &&
                      (int'(byte_index) < FRAME_BYTES);
  assign last_byte  = byte_store && (byte_index == BIDX_W'(FRAME_BYTES - 1));
  assign idle_inc   = idle_count + 8'd1;
  assign fs_inc     = failsafe_count + 8'd1;
  assign arm        = idle_inc > cfg.sync_idle_ticks;
  assign fire       = fs_inc > cfg.failsafe_ticks;
  assign read_ok    = int'(item.channel_index) < NUM_CHANNELS;
  assign read_sel   = item.channel_index[CH_W-1:0];
  assign resolution = detected_res;

  // Resolution detection once the frame is complete.
  assign detect_res = detect_resolution(info_byte, word0, word1, cfg);
  assign res_sel    = (detected_res == RES_UNKNOWN) ? detect_res : detected_res;

  // Frame buffer write: a pair is written when its low byte arrives,
  // or on its high byte when that is the last byte of the frame.
  assign ram_we    = byte_store && (byte_index[0] || last_byte);
  assign ram_waddr = PAIR_W'(byte_index >> 1);
  assign ram_wdata = byte_index[0] ? {hi_byte, item.data_byte} : {item.data_byte, 8'h00};

  // Word unpacking: word w lives in pair w + 1.
  assign pair_num   = word_num + SEQ_W'(1);
  assign pair_in    = int'(pair_num) < FRAME_PAIRS;
  assign word_cur   = pair_ok ? ram_rdata : 16'h0000;
  assign word_ch    = (detected_res == RES_TEN) ? word_cur[13:10] : word_cur[14:11];
  assign word_val   = (detected_res == RES_TEN) ? {1'b0, word_cur[9:0]} : word_cur[10:0];
  assign word_skip  = (word_cur == WORD_EMPTY);
  assign word_abort = !word_skip && (word_num != '0) &&
                      ((word_cur & cfg.second_frame_mask) != 16'h0000);
  assign word_last  = (word_num == SEQ_W'(WORDS_PER_FRAME - 1));
  assign word_write = (state == S_WORD) && !word_skip && !word_abort &&
                      (int'(word_ch) < NUM_CHANNELS);

  dsmsr_ram #(
    .WIDTH (16),
    .DEPTH (FRAME_PAIRS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pair_num[PAIR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Result word for the current step.
  always_comb begin
    res                  = '0;
    res.resolution_state = detected_res;
    res_push             = 1'b0;
    unique case (state)
      S_RUN: begin
        if (start && !last_byte) begin
          res_push = 1'b1;
          unique case (item.op)
            OP_READ: begin
              if (!read_ok) begin
                res.channel_status = ST_NO_CHANNEL;
              end else if (!fresh[read_sel]) begin
                res.channel_status = ST_TIMEOUT;
              end else begin
                res.channel_status = ST_VALID;
                res.channel_value  = store[read_sel];
              end
            end
            OP_TICK: res.failsafe_fired = fire;
            OP_BYTE, OP_NONE: begin
            end
          endcase
        end
      end
      S_DETECT: begin
        res.resolution_state = res_sel;
        if (res_sel == RES_UNKNOWN) begin
          res_push        = 1'b1;
          res.frame_event = EV_RES_UNKNOWN;
        end
      end
      S_READ: begin
      end
      S_WORD: begin
        if (word_abort) begin
          res_push        = 1'b1;
          res.frame_event = EV_FRAME_ERROR;
        end else if (word_last) begin
          res_push        = 1'b1;
          res.frame_event = EV_DECODED;
        end
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      idle_count     <= 8'd0;
      failsafe_count <= 8'd0;
      capturing      <= 1'b0;
      byte_index     <= '0;
      detected_res   <= RES_UNKNOWN;
      fresh          <= '0;
      word_num       <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (start) begin
            unique case (item.op)
              OP_BYTE: begin
                idle_count <= 8'd0;
                if (byte_store) begin
                  byte_index <= byte_index + BIDX_W'(1);
                  if (last_byte) begin
                    capturing <= 1'b0;
                    state     <= S_DETECT;
                  end
                end
              end
              OP_TICK: begin
                if (arm) begin
                  capturing  <= 1'b1;
                  byte_index <= '0;
                  idle_count <= 8'd0;
                end else begin
                  idle_count <= idle_inc;
                end
                if (fire) begin
                  fresh          <= '0;
                  failsafe_count <= 8'd0;
                end else begin
                  failsafe_count <= fs_inc;
                end
              end
              OP_READ, OP_NONE: begin
              end
            endcase
          end
        end
        S_DETECT: begin
          detected_res <= res_sel;
          word_num     <= '0;
          if (res_sel == RES_UNKNOWN) begin
            state <= S_RUN;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WORD;
        end
        S_WORD: begin
          if (word_write) begin
            fresh[word_ch[CH_W-1:0]] <= 1'b1;
          end
          if (word_abort) begin
            state <= S_RUN;
          end else if (word_last) begin
            failsafe_count <= 8'd0;
            state          <= S_RUN;
          end else begin
            word_num <= word_num + SEQ_W'(1);
            state    <= S_READ;
          end
        end
      endcase
    end
  end

  // Channel values and frame header bytes.
  always_ff @(posedge clk) begin
    if (word_write) begin
      store[word_ch[CH_W-1:0]] <= word_val;
    end
    if (state == S_READ) begin
      pair_ok <= pair_in;
    end
    if (start && (item.op == OP_TICK) && arm) begin
      // Header bytes past the end of a short frame read as zero.
      word0 <= 16'h0000;
      word1 <= 16'h0000;
    end
    if (byte_store) begin
      hi_byte <= item.data_byte;
      if (byte_index == POS_INFO) begin
        info_byte <= item.data_byte;
      end
      if (byte_index == POS_WORD0_H) begin
        word0[15:8] <= item.data_byte;
      end
      if (byte_index == POS_WORD0_L) begin
        word0[7:0] <= item.data_byte;
      end
      if (byte_index == POS_WORD1_H) begin
        word1[15:8] <= item.data_byte;
      end
      if (byte_index == POS_WORD1_L) begin
        word1[7:0] <= item.data_byte;
      end
    end
  end

endmodule

>>> sv/dsmsr_rq.sv
// Result queue: holds finished result words until they are popped.
module dsmsr_rq import dsmsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res_in,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t res_out
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign take     = pop && !empty;
  assign res_out  = slots[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, take};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res_in;
    end
  end

endmodule

>>> sv/dsm_serial_receiver_decoder_unit.sv
// Top level of the serial receiver frame decoder: configuration registers and block wiring.
//
// Input words (received byte, timer tick or channel read) are pushed into a two-entry
// queue and carried out one at a time by the execution stage; every word yields exactly
// one result word, which waits in a two-entry result queue until popped. A tick, a read
// or a byte that does not complete a frame has its result queued as it is taken. The
// byte that completes a frame is followed by resolution detection and then by a read and
// an unpacking step per channel word, set by the single registered read port of the frame
// buffer RAM, ending early when the frame is aborted or its resolution cannot be found.
// A queued result can be popped in the cycle after it is pushed. The user must write
// configuration registers only while no word is in flight; the block does not enforce it.
module dsm_serial_receiver_decoder_unit import dsmsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  channel_index,
  output logic        empty,
  input  logic        pop,
  output logic [10:0] channel_value,
  output logic [1:0]  channel_status,
  output logic [1:0]  frame_event,
  output logic        failsafe_fired,
  output logic [1:0]  resolution_state,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  logic       item_valid;
  item_t      item;
  logic       item_take;
  logic       rq_full;
  logic       back_push;
  result_t    back_res;
  result_t    rq_res;
  logic [1:0] resolution;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.second_frame_mask    <= 16'h8000;
      cfg.info_resolution_mask <= 8'h10;
      cfg.sync_idle_ticks      <= 8'd4;
      cfg.failsafe_ticks       <= 8'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECOND_FRAME_MASK:    cfg.second_frame_mask    <= cfg_data;
        REG_INFO_RESOLUTION_MASK: cfg.info_resolution_mask <= cfg_data[7:0];
        REG_SYNC_IDLE_TICKS:      cfg.sync_idle_ticks      <= cfg_data[7:0];
        REG_FAILSAFE_TICKS:       cfg.failsafe_ticks       <= cfg_data[7:0];
      endcase
    end
  end

  dsmsr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .channel_index (channel_index),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  dsmsr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_full   (rq_full),
    .res_push   (back_push),
    .res        (back_res),
    .resolution (resolution)
  );

  dsmsr_rq u_rq (
    .clk      (clk),
    .rst      (rst),
    .res_push (back_push),
    .res_in   (back_res),
    .res_full (rq_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (rq_res)
  );

  // Result fields.
  assign channel_value    = rq_res.channel_value;
  assign channel_status   = rq_res.channel_status;
  assign frame_event      = rq_res.frame_event;
  assign failsafe_fired   = rq_res.failsafe_fired;
  assign resolution_state = rq_res.resolution_state;

  // The execution stage never queues a result into a full result queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(back_push && rq_full))
    else $error("result pushed while result queue full");

  // Once detected, the resolution is kept.
  a_resolution_sticky: assert property (@(posedge clk) disable iff (rst)
    (resolution != RES_UNKNOWN) |=> (resolution != RES_UNKNOWN))
    else $error("detected resolution returned to unknown");

  // A frame result carries no channel read and no failsafe mark.
  a_event_alone: assert property (@(posedge clk) disable iff (rst)
    (back_push && (back_res.frame_event != EV_NONE)) |->
      (!back_res.failsafe_fired && (back_res.channel_status == ST_VALID) &&
       (back_res.channel_value == 11'd0)))
    else $error("frame result mixed with other fields");

endmodule

>>> tb/dsm_result_checker.sv
// Checker for the serial receiver frame decoder: predicts each result word and compares.
module dsm_result_checker import dsmsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  channel_index,
  input  logic        empty,
  input  logic        pop,
  input  logic [10:0] channel_value,
  input  logic [1:0]  channel_status,
  input  logic [1:0]  frame_event,
  input  logic        failsafe_fired,
  input  logic [1:0]  resolution_state,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          failures,
  output int          pending
);

  // Shadow of the configuration registers and of the decoder state.
  cfg_t                    regs;
  logic [7:0]              frame_bytes [FRAME_BYTES];
  logic [10:0]             chan_value [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_fresh;
  logic [7:0]              idle_ticks;
  logic [7:0]              ticks_since_frame;
  logic                    armed;
  int                      fill_count;
  logic [1:0]              resolution;
  result_t                 expected_results [$];

  // Big-endian channel word w of the captured frame; bytes past the frame read as zero.
  function automatic logic [15:0] frame_word(input int w);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (2 + 2 * w < FRAME_BYTES) ? frame_bytes[2 + 2 * w] : 8'h00;
    lo = (3 + 2 * w < FRAME_BYTES) ? frame_bytes[3 + 2 * w] : 8'h00;
    return {hi, lo};
  endfunction

  // Advances the shadow state by one input word and returns the result word it yields.
  function automatic result_t decode_item(input logic [1:0] c, input logic [7:0] b,
                                          input logic [3:0] ch);
    result_t     r;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] wd;
    logic [3:0]  num;
    logic        ten;
    logic        eleven;
    int          w;
    r = '0;
    case (c)
      CMD_BYTE: begin
        if (armed && fill_count < FRAME_BYTES) begin
          frame_bytes[fill_count] = b;
          fill_count++;
          if (fill_count == FRAME_BYTES) begin
            // Resolution is found once, then kept for good.
            if (resolution == RES_UNKNOWN) begin
              w0 = frame_word(0);
              w1 = frame_word(1);
              if ((w0 & regs.second_frame_mask) != 16'h0000) begin
                resolution = RES_UNKNOWN;
              end else if (frame_bytes[1] != 8'h00) begin
                resolution = ((frame_bytes[1] & regs.info_resolution_mask) != 8'h00) ?
                             RES_ELEVEN : RES_TEN;
              end else begin
                ten    = (w0[13:10] == 4'd1) && (w1[13:10] == 4'd5);
                eleven = (w0[14:11] == 4'd1) && (w1[14:11] == 4'd5);
                if (ten && !eleven) begin
                  resolution = RES_TEN;
                end else if (eleven && !ten) begin
                  resolution = RES_ELEVEN;
                end
              end
            end
            if (resolution == RES_UNKNOWN) begin
              r.frame_event = EV_RES_UNKNOWN;
            end else begin
              // Unpack the channel words; a second-frame mark after word 0 aborts.
              r.frame_event = EV_DECODED;
              for (w = 0; w < WORDS_PER_FRAME && r.frame_event == EV_DECODED; w++) begin
                wd = frame_word(w);
                if (wd != WORD_EMPTY) begin
                  if (w > 0 && (wd & regs.second_frame_mask) != 16'h0000) begin
                    r.frame_event = EV_FRAME_ERROR;
                  end else begin
                    num = (resolution == RES_TEN) ? wd[13:10] : wd[14:11];
                    if (num < NUM_CHANNELS) begin
                      chan_value[num] = (resolution == RES_TEN) ? {1'b0, wd[9:0]} : wd[10:0];
                      chan_fresh[num] = 1'b1;
                    end
                  end
                end
              end
              if (r.frame_event == EV_DECODED) begin
                ticks_since_frame = 8'd0;
              end
            end
            armed = 1'b0;
          end
        end
        idle_ticks = 8'd0;
      end
      CMD_TICK: begin
        idle_ticks = idle_ticks + 8'd1;
        if (idle_ticks > regs.sync_idle_ticks) begin
          armed      = 1'b1;
          fill_count = 0;
          idle_ticks = 8'd0;
        end
        ticks_since_frame = ticks_since_frame + 8'd1;
        if (ticks_since_frame > regs.failsafe_ticks) begin
          chan_fresh        = '0;
          ticks_since_frame = 8'd0;
          r.failsafe_fired  = 1'b1;
        end
      end
      CMD_READ: begin
        if (ch >= NUM_CHANNELS) begin
          r.channel_status = ST_NO_CHANNEL;
        end else if (!chan_fresh[ch]) begin
          r.channel_status = ST_TIMEOUT;
        end else begin
          r.channel_status = ST_VALID;
          r.channel_value  = chan_value[ch];
        end
      end
      default: begin
      end
    endcase
    r.resolution_state = resolution;
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Follow the configuration, input and result channels at every clock edge.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      regs              = '{16'h8000, 8'h10, 8'd4, 8'd64};
      frame_bytes       = '{default: 8'h00};
      chan_value        = '{default: 11'd0};
      chan_fresh        = '0;
      idle_ticks        = 8'd0;
      ticks_since_frame = 8'd0;
      armed             = 1'b0;
      fill_count        = 0;
      resolution        = RES_UNKNOWN;
      failures          = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SECOND_FRAME_MASK:    regs.second_frame_mask    = cfg_data;
          REG_INFO_RESOLUTION_MASK: regs.info_resolution_mask = cfg_data[7:0];
          REG_SYNC_IDLE_TICKS:      regs.sync_idle_ticks      = cfg_data[7:0];
          REG_FAILSAFE_TICKS:       regs.failsafe_ticks       = cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: value %0d status %0d event %0d",
                   $time, channel_value, channel_status, frame_event);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("channel_value", want.channel_value, channel_value);
          check_field("channel_status", 11'(want.channel_status), 11'(channel_status));
          check_field("frame_event", 11'(want.frame_event), 11'(frame_event));
          check_field("failsafe_fired", 11'(want.failsafe_fired), 11'(failsafe_fired));
          check_field("resolution_state", 11'(want.resolution_state), 11'(resolution_state));
        end
      end
      if (push && !full) begin
        expected_results.push_back(decode_item(cmd, data_byte, channel_index));
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the serial receiver frame decoder: clock, reset, stimulus and verdict.
module tb_top;
  import dsmsr_pkg::*;

  // The command code that the block answers without acting on it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 80;

  logic        clk;
  logic        rst           = 1'b1;
  logic        push          = 1'b0;
  logic [1:0]  cmd           = CMD_BYTE;
  logic [7:0]  data_byte     = 8'h00;
  logic [3:0]  channel_index = 4'd0;
  logic        pop           = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = REG_SECOND_FRAME_MASK;
  logic [15:0] cfg_data      = 16'h0000;
  logic        full;
  logic        empty;
  logic [10:0] channel_value;
  logic [1:0]  channel_status;
  logic [1:0]  frame_event;
  logic        failsafe_fired;
  logic [1:0]  resolution_state;

  int fail_count;
  int pending_count;

  // Traffic shaping, shared between the sender and the receiver.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int items_sent      = 0;

  // Stimulus copy of the settings that shape frames.
  int          sync_ticks = 4;
  logic [15:0] frame_mark = 16'h8000;
  logic [7:0]  info_mask  = 8'h10;
  int          word_shift;
  logic        by_info;
  logic        res_locked = 1'b0;

  dsm_serial_receiver_decoder_unit DUT (.*);

  dsm_result_checker u_check (.*, .failures(fail_count), .pending(pending_count));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, and one long hold-off counted here when asked for.
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one word, idling first at random, and returns once it is accepted.
  task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic [3:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    cmd           <= c;
    data_byte     <= b;
    channel_index <= ch;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result word has been popped.
  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_config(input logic [15:0] mark, input logic [7:0] imask,
                            input logic [7:0] sync, input logic [7:0] fsafe);
    wait_for_results();
    write_reg(REG_SECOND_FRAME_MASK, mark);
    write_reg(REG_INFO_RESOLUTION_MASK, {8'h00, imask});
    write_reg(REG_SYNC_IDLE_TICKS, {8'h00, sync});
    write_reg(REG_FAILSAFE_TICKS, {8'h00, fsafe});
    cfg_we     <= 1'b0;
    frame_mark = mark;
    info_mask  = imask;
    sync_ticks = sync;
  endtask

  // Reads, ticks, unused commands, stray bytes, and now and then a long run of ticks.
  task automatic send_noise();
    int kind;
    kind = $urandom_range(99);
    if (kind < 3) begin
      repeat ($urandom_range(1, 80)) send_item(CMD_TICK, 8'($urandom), 4'($urandom));
    end else if (kind < 55) begin
      send_item(CMD_READ, 8'($urandom), 4'($urandom));
    end else if (kind < 70) begin
      send_item(CMD_TICK, 8'($urandom), 4'($urandom));
    end else if (kind < 80) begin
      send_item(CMD_UNUSED, 8'($urandom), 4'($urandom));
    end else begin
      send_item(CMD_BYTE, 8'($urandom), 4'($urandom));
    end
  endtask

  // Idle gap, then a frame with random channel words; some frames are broken on purpose.
  task automatic send_frame();
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] wd;
    logic        detecting;
    int          n_ticks;
    int          n_bytes;
    int          k;
    int          pick;
    int          bad;
    detecting = !res_locked;
    if (!detecting && $urandom_range(9) == 0) begin
      n_ticks = $urandom_range(sync_ticks);
    end else begin
      n_ticks = sync_ticks + 1 + $urandom_range(2);
    end
    repeat (n_ticks) send_item(CMD_TICK, 8'($urandom), 4'($urandom));

    fb[0] = 8'($urandom);
    fb[1] = 8'($urandom);
    for (k = 0; k < WORDS_PER_FRAME; k++) begin
      pick = $urandom_range(99);
      if (detecting) begin
        // Channels 1 and 5 lead, as the channel-order detection expects.
        wd = 16'((k == 0) ? 1 : (k == 1) ? 5 : $urandom_range(11)) << word_shift;
        wd = wd | (16'($urandom) & ((16'd1 << word_shift) - 16'd1));
      end else if (pick < 8) begin
        wd = WORD_EMPTY;
      end else if (pick < 16) begin
        wd = 16'($urandom);
      end else begin
        wd = 16'($urandom_range(15)) << word_shift;
        wd = wd | (16'($urandom) & ((16'd1 << word_shift) - 16'd1));
      end
      fb[2 + 2 * k] = wd[15:8];
      fb[3 + 2 * k] = wd[7:0];
    end

    if (detecting) begin
      if (by_info) begin
        fb[1] = (word_shift == 11) ? (fb[1] | info_mask) : (fb[1] & ~info_mask);
        if (fb[1] == 8'h00) begin
          fb[1] = 8'h01;
        end
      end else begin
        fb[1] = 8'h00;
      end
      res_locked = 1'b1;
    end else if ($urandom_range(99) < 10) begin
      // Second-frame mark on a later word aborts the frame.
      bad = $urandom_range(1, WORDS_PER_FRAME - 1);
      fb[2 + 2 * bad] = fb[2 + 2 * bad] | frame_mark[15:8];
      fb[3 + 2 * bad] = fb[3 + 2 * bad] | frame_mark[7:0];
    end

    n_bytes = (!detecting && $urandom_range(9) == 0) ?
              $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    for (k = 0; k < n_bytes; k++) begin
      send_item(CMD_BYTE, fb[k], 4'($urandom));
    end
  endtask

  // Mostly frames with some noise between them; frames cannot arm at the longest gap.
  task automatic run_phase(input int budget);
    int end_at;
    end_at = items_sent + budget;
    while (items_sent < end_at) begin
      if (sync_ticks < 255 && $urandom_range(99) < 70) begin
        send_frame();
      end
      repeat ($urandom_range(3)) send_noise();
    end
  endtask

  // Main stimulus and verdict.
  initial begin : stimulus
    int k;
    word_shift = ($urandom_range(1) == 1) ? 11 : 10;
    by_info    = 1'($urandom_range(1));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reads of never-written and missing channels, the unused command, stray bytes.
    send_item(CMD_READ, 8'h00, 4'd0);
    send_item(CMD_READ, 8'hff, 4'd11);
    send_item(CMD_READ, 8'h00, 4'd12);
    send_item(CMD_READ, 8'hff, 4'd15);
    send_item(CMD_UNUSED, 8'ha5, 4'd7);
    send_item(CMD_BYTE, 8'h00, 4'd0);
    send_item(CMD_BYTE, 8'hff, 4'd15);

    // A frame whose first word carries the second-frame mark leaves resolution unknown.
    repeat (5) send_item(CMD_TICK, 8'h00, 4'd0);
    for (k = 0; k < FRAME_BYTES; k++) begin
      send_item(CMD_BYTE, (k == 2) ? 8'hc4 : 8'($urandom), 4'd0);
    end

    run_phase(200);

    set_config(16'h8000, 8'hff, 8'd1, 8'd1);
    sender_idle_pct = 71;
    run_phase(280);

    // Longest gap and failsafe: nothing arms, both tick counters wrap.
    set_config(16'h4000, 8'h00, 8'd255, 8'd255);
    sender_idle_pct = 0;
    recv_stall_pct  = 71;
    repeat (300) send_item(CMD_TICK, 8'($urandom), 4'($urandom));
    run_phase(100);

    set_config(16'hffff, 8'h10, 8'd3, 8'd10);
    sender_idle_pct = 36;
    recv_stall_pct  = 36;
    run_phase(230);

    // Receiver holds off while the sender keeps offering words.
    set_config(16'h0000, 8'h55, 8'd2, 8'd200);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req++;
    run_phase(300);

    // Sender pauses in the middle until every result has arrived.
    set_config(16'h8000, 8'h10, 8'd4, 8'd64);
    sender_idle_pct = 36;
    recv_stall_pct  = 36;
    run_phase(150);
    wait_for_results();
    run_phase(150);

    wait_for_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
